// ===== rtl/core/vcvc_pkg.sv =====
// Shared types, constants and small tables for the vertex clip/viewport/cull core.
// No dependencies; every other file in rtl/core except vcvc_ifs imports this package.
package vcvc_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int SCREEN_W_DEF    = 1280;
  localparam int SCREEN_H_DEF    = 720;

  localparam int SLOT_W    = 12;
  localparam int POS_W     = 32;
  localparam int TAG_W     = 32;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 64;
  localparam int ENTRY_W   = 64;
  localparam int ACC_W     = 52;
  localparam int QUOT_W    = 26;
  localparam int SX_W      = 19;
  localparam int SY_W      = 18;
  localparam int DZ_W      = 26;
  localparam int AREA_W    = 21;

  localparam logic [QUOT_W-1:0] DEPTH_SCALE = 26'h3ffffff;
  localparam logic [ENTRY_W-1:0] CLIPPED_ENTRY = {1'b1, {(ENTRY_W-1){1'b0}}};

  localparam logic [REG_W-1:0] MATRIX_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_VERTEX   = 2'd0,
    STAT_DRAWN    = 2'd1,
    STAT_CLIPPED  = 2'd2,
    STAT_BACKFACE = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                        kind;
    logic                         slot_ok;
    logic [SLOT_W-1:0]            slot;
    logic [POS_W-1:0]             pos_x;
    logic [POS_W-1:0]             pos_y;
    logic [POS_W-1:0]             pos_z;
    logic [TAG_W-1:0]             tag;
    logic [2:0][SLOT_W-1:0]       corner;
    logic [2:0]                   corner_ok;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  num;
    logic [QUOT_W-1:0] scale;
    logic [ACC_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MAT, B_CLIP, B_DX, B_DY, B_DZ, B_STORE,
    B_READ, B_AREA, B_CULL, B_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    D_IDLE, D_MLO, D_MHI, D_RUN
  } div_state_t;

  // Matrix walk: step s covers row s/3, column s%3 (twelve products).
  function automatic logic [1:0] step_row(input logic [3:0] s);
    logic [1:0] r;
    case (s)
      4'd0, 4'd1, 4'd2:   r = 2'd0;
      4'd3, 4'd4, 4'd5:   r = 2'd1;
      4'd6, 4'd7, 4'd8:   r = 2'd2;
      default:            r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] step_col(input logic [3:0] s);
    logic [1:0] c;
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9:  c = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: c = 2'd1;
      default:                 c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/vcvc_ifs.sv =====
// Valid/ready channel interfaces for items and results of the vertex core.
// Widths are fixed by the item and result formats; no package needed.
interface vcvc_item_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [11:0]        vertex_slot;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0]        triangle_id;
  logic [11:0]        corner_a;
  logic [11:0]        corner_b;
  logic [11:0]        corner_c;

  modport source (output valid, func, vertex_slot, pos_x, pos_y, pos_z, triangle_id,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, func, vertex_slot, pos_x, pos_y, pos_z, triangle_id,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface vcvc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [18:0] screen_x;
  logic [17:0] screen_y;
  logic [25:0] depth_value;
  logic        outside;
  logic [31:0] triangle_tag;
  logic [1:0]  corner_number;
  logic        last;

  modport source (output valid, status, screen_x, screen_y, depth_value, outside,
                  triangle_tag, corner_number, last, input ready);
  modport sink   (input valid, status, screen_x, screen_y, depth_value, outside,
                  triangle_tag, corner_number, last, output ready);
endinterface

// ===== rtl/core/vcvc_front.sv =====
// Front end: accepts item words, classifies them and queues them (two entries).
// Depends on vcvc_pkg and vcvc_item_if.
module vcvc_front import vcvc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  vcvc_item_if.sink   item,
  output logic        q_valid,
  input  logic        q_pop,
  output item_t       q_item
);

  item_t      cls;
  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;

  function automatic logic in_store(input logic [SLOT_W-1:0] s);
    return 32'(s) < 32'(STORE_DEPTH);
  endfunction

  always_comb begin
    cls.kind      = item.func ? KIND_TRIANGLE : KIND_VERTEX;
    cls.slot      = item.vertex_slot;
    cls.slot_ok   = in_store(item.vertex_slot);
    cls.pos_x     = item.pos_x;
    cls.pos_y     = item.pos_y;
    cls.pos_z     = item.pos_z;
    cls.tag       = item.triangle_id;
    cls.corner[0] = item.corner_a;
    cls.corner[1] = item.corner_b;
    cls.corner[2] = item.corner_c;
    cls.corner_ok = {in_store(item.corner_c), in_store(item.corner_b),
                     in_store(item.corner_a)};
  end

  assign item.ready = (fill != 2'd2);
  assign push       = item.valid && item.ready;
  assign q_valid    = (fill != 2'd0);
  assign q_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/core/vcvc_div.sv =====
// Multiply-then-divide unit: floor(num*scale/den), one quotient bit per cycle.
// Depends on vcvc_pkg (request/response structs, state enum).
module vcvc_div import vcvc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int PROD_W = ACC_W + QUOT_W;
  localparam int CNT_W  = $clog2(QUOT_W);

  div_state_t          state, state_next;
  logic [ACC_W-1:0]    num, den, rem;
  logic [QUOT_W-1:0]   scale, low, quot;
  logic [PROD_W-1:0]   prod, full;
  logic [ACC_W-1:0]    hi_part;
  logic [CNT_W-1:0]    cnt;
  logic [ACC_W:0]      trial;
  logic                fits;
  logic                done;

  assign hi_part = ACC_W'(num[ACC_W-1:QUOT_W]) * ACC_W'(scale);
  assign full    = prod + {hi_part, {QUOT_W{1'b0}}};
  assign trial   = {rem, low[QUOT_W-1]};
  assign fits    = trial >= {1'b0, den};

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE:  if (req.start) state_next = D_MLO;
      D_MLO:   state_next = D_MHI;
      D_MHI:   state_next = D_RUN;
      D_RUN:   if (cnt == CNT_W'(QUOT_W - 1)) state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == D_RUN) && (cnt == CNT_W'(QUOT_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        num   <= req.num;
        scale <= req.scale;
        den   <= req.den;
      end
      D_MLO: begin
        prod <= PROD_W'(ACC_W'(num[QUOT_W-1:0]) * ACC_W'(scale));
      end
      D_MHI: begin
        // high remainder is already below den, so only QUOT_W steps remain
        rem <= full[PROD_W-1:QUOT_W];
        low <= full[QUOT_W-1:0];
        cnt <= '0;
      end
      D_RUN: begin
        rem  <= fits ? ACC_W'(trial - {1'b0, den}) : trial[ACC_W-1:0];
        low  <= {low[QUOT_W-2:0], 1'b0};
        quot <= {quot[QUOT_W-2:0], fits};
        cnt  <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp = {done, quot};

endmodule

// ===== rtl/core/vcvc_back.sv =====
// Back end: matrix transform, clip test, viewport mapping, vertex store and culling.
// Depends on vcvc_pkg, vcvc_result_if and the vcvc_div unit (via struct ports).
module vcvc_back import vcvc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int SCREEN_W    = SCREEN_W_DEF,
  parameter int SCREEN_H    = SCREEN_H_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  item_t                q_item,
  output div_req_t             div_req,
  input  div_rsp_t             div_rsp,
  vcvc_result_if.source        result
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [QUOT_W-1:0] SCALE_X = QUOT_W'((SCREEN_W - 1) * 256);
  localparam logic [QUOT_W-1:0] SCALE_Y = QUOT_W'((SCREEN_H - 1) * 256);

  back_state_t             state, state_next;
  logic [REG_W-1:0]        regs [NUM_REGS];
  item_t                   cur;
  logic signed [ACC_W-1:0] acc [4];
  logic signed [63:0]      prod;
  logic [3:0]              step;
  logic [1:0]              cur_row, cur_col, acc_row;
  logic [REG_W-1:0]        mreg;
  logic [31:0]             m_coef, m_pos;

  logic signed [ACC_W:0]   xpw, wmx, ypw, wmy, zpw, wmz;
  logic                    clip_out;
  logic [ACC_W-1:0]        t2;

  logic [SX_W-1:0]         sx;
  logic [SY_W-1:0]         sy;
  logic [ENTRY_W-1:0]      v [3];

  logic [ENTRY_W-1:0]      store [STORE_DEPTH];
  logic [ENTRY_W-1:0]      rd_q;
  logic [AW-1:0]           rd_addr;
  logic [1:0]              rc, rc_sel;
  logic                    oor_d;

  logic signed [AREA_W-1:0]   ex [3], ey [3];
  logic signed [2*AREA_W-1:0] p1, p2;
  logic signed [2*AREA_W:0]   area;
  logic                       any_out;

  status_t                 e_status;
  logic [1:0]              e_last, ecnt;
  logic [TAG_W-1:0]        e_tag;
  logic                    res_load;
  logic [ENTRY_W-1:0]      e_entry;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= MATRIX_RESET;
    end else if (wr_en) begin
      regs[wr_index] <= wr_data;
    end
  end

  // ---- matrix walk selection ----
  always_comb begin
    cur_row = step_row(step);
    cur_col = step_col(step);
    acc_row = step_row(step - 4'd1);
    mreg    = regs[{cur_row, cur_col[1]}];
    m_coef  = cur_col[0] ? mreg[63:32] : mreg[31:0];
    case (cur_col)
      2'd0:    m_pos = cur.pos_x;
      2'd1:    m_pos = cur.pos_y;
      default: m_pos = cur.pos_z;
    endcase
  end

  // ---- clip test ----
  always_comb begin
    xpw = (ACC_W+1)'(acc[0]) + (ACC_W+1)'(acc[3]);
    wmx = (ACC_W+1)'(acc[3]) - (ACC_W+1)'(acc[0]);
    ypw = (ACC_W+1)'(acc[1]) + (ACC_W+1)'(acc[3]);
    wmy = (ACC_W+1)'(acc[3]) - (ACC_W+1)'(acc[1]);
    zpw = (ACC_W+1)'(acc[2]) + (ACC_W+1)'(acc[3]);
    wmz = (ACC_W+1)'(acc[3]) - (ACC_W+1)'(acc[2]);
    clip_out = (acc[3] <= 0) || (xpw < 0) || (wmx < 0) || (ypw < 0) || (wmy < 0) ||
               (zpw < 0) || (wmz < 0);
    t2 = {acc[3][ACC_W-2:0], 1'b0};
  end

  // ---- signed area on stored Q.8 coordinates ----
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = AREA_W'(v[i][SX_W-1:0]);
      ey[i] = AREA_W'(v[i][SX_W+SY_W-1:SX_W]);
    end
    area    = (2*AREA_W+1)'(p1) + (2*AREA_W+1)'(p2);
    any_out = v[0][ENTRY_W-1] | v[1][ENTRY_W-1] | v[2][ENTRY_W-1];
  end

  assign rc_sel  = (rc == 2'd3) ? 2'd0 : rc;
  assign rd_addr = AW'(cur.corner[rc_sel]);
  assign e_entry = v[ecnt];

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    res_load   = 1'b0;
    div_req    = '0;
    div_req.den = t2;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = (q_item.kind == KIND_VERTEX) ? B_MAT : B_READ;
        end
      end
      B_MAT:  if (step == 4'd12) state_next = B_CLIP;
      B_CLIP: begin
        if (clip_out) begin
          state_next = B_STORE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = ACC_W'(xpw);
          div_req.scale = SCALE_X;
          state_next    = B_DX;
        end
      end
      B_DX: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = ACC_W'(wmy);
          div_req.scale = SCALE_Y;
          state_next    = B_DY;
        end
      end
      B_DY: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = ACC_W'(zpw);
          div_req.scale = DEPTH_SCALE;
          state_next    = B_DZ;
        end
      end
      B_DZ:    if (div_rsp.done) state_next = B_STORE;
      B_STORE: state_next = B_EMIT;
      B_READ:  if (rc == 2'd3) state_next = B_AREA;
      B_AREA:  state_next = B_CULL;
      B_CULL:  state_next = B_EMIT;
      B_EMIT: begin
        if (!result.valid || result.ready) begin
          res_load = 1'b1;
          if (ecnt == e_last) state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur  <= q_item;
        step <= '0;
        rc   <= '0;
        for (int r = 0; r < 4; r++) begin
          acc[r] <= ACC_W'($signed(regs[2*r+1][63:32]));
        end
      end
      B_MAT: begin
        step <= step + 4'd1;
        if (step != 4'd12) begin
          prod <= $signed(m_coef) * $signed(m_pos);
        end
        if (step != 4'd0) begin
          acc[acc_row] <= acc[acc_row] + ACC_W'(prod >>> 16);
        end
      end
      B_CLIP: if (clip_out) v[0] <= CLIPPED_ENTRY;
      B_DX:   if (div_rsp.done) sx <= div_rsp.quot[SX_W-1:0];
      B_DY:   if (div_rsp.done) sy <= div_rsp.quot[SY_W-1:0];
      B_DZ: begin
        if (div_rsp.done) v[0] <= {1'b0, div_rsp.quot[DZ_W-1:0], sy, sx};
      end
      B_STORE: begin
        e_status <= STAT_VERTEX;
        e_last   <= 2'd0;
        e_tag    <= '0;
        ecnt     <= 2'd0;
      end
      B_READ: begin
        // read data is registered, so it lands in the cycle after its address
        rc    <= rc + 2'd1;
        oor_d <= !cur.corner_ok[rc_sel];
        if (rc != 2'd0) v[rc - 2'd1] <= oor_d ? CLIPPED_ENTRY : rd_q;
      end
      B_AREA: begin
        p1 <= (ey[1] - ey[2]) * (ex[0] - ex[2]);
        p2 <= (ex[2] - ex[1]) * (ey[0] - ey[2]);
      end
      B_CULL: begin
        e_tag <= cur.tag;
        ecnt  <= 2'd0;
        if (any_out) begin
          e_status <= STAT_CLIPPED;
          e_last   <= 2'd0;
          v[0]     <= '0;
        end else if (area >= 0) begin
          e_status <= STAT_BACKFACE;
          e_last   <= 2'd0;
          v[0]     <= '0;
        end else begin
          e_status <= STAT_DRAWN;
          e_last   <= 2'd2;
        end
      end
      B_EMIT: if (res_load) ecnt <= ecnt + 2'd1;
      default: ;
    endcase
  end

  // ---- vertex store ----
  always_ff @(posedge clk) begin
    if (state == B_STORE && cur.slot_ok) begin
      store[AW'(cur.slot)] <= v[0];
    end
    rd_q <= store[rd_addr];
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.status        <= e_status;
      result.screen_x      <= e_entry[SX_W-1:0];
      result.screen_y      <= e_entry[SX_W+SY_W-1:SX_W];
      result.depth_value   <= e_entry[ENTRY_W-2:SX_W+SY_W];
      result.outside       <= e_entry[ENTRY_W-1];
      result.triangle_tag  <= e_tag;
      result.corner_number <= (e_status == STAT_DRAWN) ? ecnt : 2'd0;
      result.last          <= (ecnt == e_last);
    end
  end

endmodule

// ===== rtl/core/vertex_clip_viewport_cull_core.sv =====
// Top level of the vertex transform / clip / viewport / cull core.
// Depends on vcvc_pkg, vcvc_ifs, vcvc_front, vcvc_div and vcvc_back.
//
//   channel   dir  handshake     word
//   item      in   valid/ready   vertex (func=0) or triangle (func=1)
//   result    out  valid/ready   one vertex result, one cull result or three corners
//   wr_*      in   wr_en only    matrix register write, index 0..7
//
// A vertex word runs its matrix products through one 32x32 multiplier, then,
// unless it clips, three quotient runs of the bit-serial divider. A triangle
// word reads its corners (single store read port), culls, then emits its results.
// The front queue holds two words, so up to two words are taken while the back
// works or the result register is stalled. Reset is synchronous; the store has no clear.
module vertex_clip_viewport_cull_core import vcvc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int SCREEN_W    = SCREEN_W_DEF,
  parameter int SCREEN_H    = SCREEN_H_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  vcvc_item_if.sink            item,
  vcvc_result_if.source        result
);

  logic     q_valid;
  logic     q_pop;
  item_t    q_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  vcvc_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  vcvc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  vcvc_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .SCREEN_W    (SCREEN_W),
    .SCREEN_H    (SCREEN_H)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .result   (result)
  );

endmodule

// ===== rtl/core/vcvc_checker.sv =====
// Port-level checks for the vertex core result channel, bound to the top level.
// Depends on vcvc_pkg (status codes).
module vcvc_port_checks import vcvc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  status,
  input logic [1:0]  corner_number,
  input logic        last,
  input logic        outside,
  input logic [31:0] triangle_tag
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_corner: assert property (@(posedge clk) disable iff (rst)
    res_valid && corner_number != 2'd0 |-> status == STAT_DRAWN)
    else $error("corner number on a non-corner result");

  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> status == STAT_DRAWN && corner_number != 2'd2)
    else $error("last missing on a final result");

  a_outside: assert property (@(posedge clk) disable iff (rst)
    res_valid && outside |-> status == STAT_VERTEX && triangle_tag == 32'd0)
    else $error("outside flag on a triangle result");

endmodule

bind vertex_clip_viewport_cull_core vcvc_port_checks u_vcvc_port_checks (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .status        (result.status),
  .corner_number (result.corner_number),
  .last          (result.last),
  .outside       (result.outside),
  .triangle_tag  (result.triangle_tag)
);

// ===== sim/vcvc_checker.sv =====
// Result checker for the vertex clip/viewport/cull core: snoops the register port
// and both channels, predicts every result and compares it field by field.
// Depends on vcvc_pkg and the channel interfaces in vcvc_ifs.
module vcvc_checker import vcvc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  vcvc_item_if                 item,
  vcvc_result_if               result,
  output int                   errors,
  output int                   pending
);

  typedef struct {
    status_t     status;
    logic [18:0] screen_x;
    logic [17:0] screen_y;
    logic [25:0] depth_value;
    logic        outside;
    logic [31:0] triangle_tag;
    logic [1:0]  corner_number;
    logic        last;
  } screen_word_t;

  logic [REG_W-1:0]   matrix [NUM_REGS];
  logic [ENTRY_W-1:0] vertex_mem [STORE_DEPTH_DEF];
  screen_word_t       due_q [$];

  initial begin
    errors  = 0;
    pending = 0;
    foreach (vertex_mem[i]) vertex_mem[i] = '0;
  end

  function automatic logic signed [63:0] coef(int r, int c);
    logic [63:0] rv;
    logic [31:0] half;
    rv = matrix[r * 2 + c / 2];
    half = (c % 2) ? rv[63:32] : rv[31:0];
    return {{32{half[31]}}, half};
  endfunction

  // Transform, clip test and viewport map; returns the packed store entry.
  function automatic logic [63:0] project_vertex(logic signed [31:0] px, py, pz);
    logic signed [63:0] p [3];
    logic signed [63:0] c [4];
    logic signed [63:0] prod;
    logic [127:0]       n;
    logic [63:0]        t2, sx, sy, dz;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int r = 0; r < 4; r++) begin
      c[r] = coef(r, 3);
      for (int k = 0; k < 3; k++) begin
        prod = coef(r, k) * p[k];
        c[r] += prod >>> 16;
      end
    end
    if (c[3] <= 0 || c[0] < -c[3] || c[0] > c[3] || c[1] < -c[3] ||
        c[1] > c[3] || c[2] < -c[3] || c[2] > c[3])
      return CLIPPED_ENTRY;
    t2 = 64'(c[3] * 2);
    n = 128'(64'(c[0] + c[3])) * 128'((SCREEN_W_DEF - 1) * 256);
    sx = 64'(n / t2);
    n = 128'(64'(c[3] - c[1])) * 128'((SCREEN_H_DEF - 1) * 256);
    sy = 64'(n / t2);
    n = 128'(64'(c[2] + c[3])) * 128'(DEPTH_SCALE);
    dz = 64'(n / t2);
    return {1'b0, dz[25:0], sy[17:0], sx[18:0]};
  endfunction

  function automatic screen_word_t unpack_entry(status_t st, logic [63:0] e,
                                                logic [31:0] tag, logic [1:0] cn,
                                                logic lst);
    screen_word_t w;
    w.status        = st;
    w.screen_x      = e[18:0];
    w.screen_y      = e[36:19];
    w.depth_value   = e[62:37];
    w.outside       = e[63];
    w.triangle_tag  = tag;
    w.corner_number = cn;
    w.last          = lst;
    return w;
  endfunction

  task automatic cmp(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    logic [63:0]    v [3];
    logic [63:0]    e;
    longint         x [3], y [3], area;
    screen_word_t   want;
    logic [11:0]    corners [3];
    if (rst) begin
      foreach (matrix[i]) matrix[i] = MATRIX_RESET[i];
      due_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (due_q.size() == 0) begin
          $error("result word with no expected result pending");
          errors++;
        end else begin
          want = due_q.pop_front();
          cmp("status", want.status, result.status);
          cmp("screen_x", want.screen_x, result.screen_x);
          cmp("screen_y", want.screen_y, result.screen_y);
          cmp("depth_value", want.depth_value, result.depth_value);
          cmp("outside", want.outside, result.outside);
          cmp("triangle_tag", want.triangle_tag, result.triangle_tag);
          cmp("corner_number", want.corner_number, result.corner_number);
          cmp("last", want.last, result.last);
        end
      end
      if (item.valid && item.ready) begin
        if (kind_t'(item.func) == KIND_VERTEX) begin
          e = project_vertex(item.pos_x, item.pos_y, item.pos_z);
          vertex_mem[item.vertex_slot] = e;
          due_q.push_back(unpack_entry(STAT_VERTEX, e, '0, 2'd0, 1'b1));
        end else begin
          corners[0] = item.corner_a;
          corners[1] = item.corner_b;
          corners[2] = item.corner_c;
          for (int i = 0; i < 3; i++) begin
            v[i] = vertex_mem[corners[i]];
            x[i] = v[i][18:0];
            y[i] = v[i][36:19];
          end
          area = (y[1] - y[2]) * (x[0] - x[2]) + (x[2] - x[1]) * (y[0] - y[2]);
          if (v[0][63] | v[1][63] | v[2][63])
            due_q.push_back(unpack_entry(STAT_CLIPPED, '0, item.triangle_id, 2'd0, 1'b1));
          else if (area >= 0)
            due_q.push_back(unpack_entry(STAT_BACKFACE, '0, item.triangle_id, 2'd0, 1'b1));
          else
            for (int i = 0; i < 3; i++)
              due_q.push_back(unpack_entry(STAT_DRAWN, v[i], item.triangle_id,
                                           2'(i), i == 2));
        end
      end
      if (wr_en) matrix[wr_index] = wr_data;
    end
    pending = due_q.size();
  end

endmodule

// ===== sim/vertex_clip_viewport_cull_core_tb.sv =====
// Testbench top for vertex_clip_viewport_cull_core: drives items, register writes
// and result back-pressure; vcvc_checker does the prediction and comparison.
// Depends on vcvc_pkg, vcvc_ifs, the core RTL and sim/vcvc_checker.sv.
module vertex_clip_viewport_cull_core_tb;
  import vcvc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [REG_W-1:0]     wr_data = '0;
  int                   errors, pending;
  int                   send_idle = 0, recv_idle = 0;
  int                   stall_cnt = 0;
  bit                   hold_req = 0;
  int                   hold_left = 0;
  bit                   written [STORE_DEPTH_DEF];
  logic [11:0]          written_q [$];

  vcvc_item_if   item_ch ();
  vcvc_result_if result_ch ();

  vertex_clip_viewport_cull_core u_top (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .item(item_ch), .result(result_ch)
  );

  vcvc_checker u_checker (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .item(item_ch), .result(result_ch), .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    item_ch.valid = 1'b0;
    item_ch.func = KIND_VERTEX;
    item_ch.vertex_slot = '0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.pos_z = '0;
    item_ch.triangle_id = '0;
    item_ch.corner_a = '0;
    item_ch.corner_b = '0;
    item_ch.corner_c = '0;
    result_ch.ready = 1'b0;
  end

  // Result side: random back-pressure, plus one long hold on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_word(kind_t kind, logic [11:0] slot, logic [31:0] px, py, pz,
                           logic [31:0] id, logic [11:0] ca, cb, cc);
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.func        <= kind;
    item_ch.vertex_slot <= slot;
    item_ch.pos_x       <= px;
    item_ch.pos_y       <= py;
    item_ch.pos_z       <= pz;
    item_ch.triangle_id <= id;
    item_ch.corner_a    <= ca;
    item_ch.corner_b    <= cb;
    item_ch.corner_c    <= cc;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_vertex(logic [11:0] slot, logic [31:0] px, py, pz);
    send_word(KIND_VERTEX, slot, px, py, pz, $urandom, 12'($urandom), 12'($urandom),
              12'($urandom));
    if (!written[slot]) begin
      written[slot] = 1;
      written_q.push_back(slot);
    end
  endtask

  task automatic send_triangle(logic [31:0] id, logic [11:0] ca, cb, cc);
    send_word(KIND_TRIANGLE, 12'($urandom), $urandom, $urandom, $urandom, id, ca, cb, cc);
  endtask

  task automatic write_matrix(logic [63:0] m [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      wr_en    <= 1'b1;
      wr_index <= REG_IDX_W'(i);
      wr_data  <= m[i];
      @(negedge clk);
    end
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] near_pos();
    return 32'($signed($urandom_range(2 * ONE)) - ONE);
  endfunction

  function automatic logic [11:0] pick_written();
    return written_q[$urandom_range(written_q.size() - 1)];
  endfunction

  task automatic random_items(int n);
    logic [11:0] s [3];
    int          cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(3) != 0) begin
        for (int i = 0; i < 3; i++) begin
          s[i] = 12'($urandom);
          send_vertex(s[i], near_pos(), near_pos(), near_pos());
        end
        if ($urandom_range(1)) send_triangle($urandom, s[0], s[1], s[2]);
        else                   send_triangle($urandom, s[0], s[2], s[1]);
        cnt += 4;
      end else begin
        if ($urandom_range(1))
          send_vertex(12'($urandom), $urandom, $urandom, $urandom);
        else
          send_triangle($urandom, pick_written(), pick_written(), pick_written());
        cnt++;
      end
    end
  endtask

  initial begin
    logic [63:0] m [NUM_REGS];
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on the reset (identity) matrix.
    send_vertex(12'd0, 0, 0, 0);
    send_vertex(12'd4095, ONE, ONE, ONE);
    send_vertex(12'd1, -ONE, -ONE, -ONE);
    send_vertex(12'd2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(12'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(12'd4, ONE + 1, 0, 0);
    send_vertex(12'd5, ONE / 2, -ONE / 2, 0);
    send_vertex(12'haaa, -ONE / 2, ONE / 2, ONE / 4);
    send_vertex(12'h555, ONE / 4, ONE / 4, -ONE / 4);
    send_triangle(32'h0, 12'd1, 12'd4095, 12'd5);
    send_triangle(32'hffff_ffff, 12'd1, 12'd5, 12'd4095);
    send_triangle(32'h1234_5678, 12'd0, 12'd0, 12'd0);
    send_triangle(32'hdead_0001, 12'd2, 12'd0, 12'd1);
    send_triangle(32'hdead_0002, 12'd0, 12'd1, 12'd3);
    send_triangle(32'hdead_0003, 12'd4, 12'd4, 12'd4);
    send_triangle($urandom, 12'haaa, 12'h555, 12'd5);
    send_triangle($urandom, 12'haaa, 12'd5, 12'h555);
    drain();

    // Scaled, sheared and translated; sender and receiver both idle.
    m = '{64'h0000_0000_0000_8000, 64'h0000_2000_0000_0000,
          64'h0000_8000_0000_1000, 64'hffff_e000_0000_0000,
          64'h0000_4000_0000_0000, 64'h0000_0000_0000_c000,
          64'h0,                   64'h0001_0000_0000_0000};
    write_matrix(m);
    send_idle = 35;
    recv_idle = 54;
    random_items(90);
    drain();

    // Perspective: w = z/2 + 2.
    m = '{64'h0000_0000_0001_0000, 64'h0,
          64'h0001_0000_0000_0000, 64'h0,
          64'h0,                   64'h0000_0000_0001_0000,
          64'h0,                   64'h0002_0000_0000_8000};
    write_matrix(m);
    send_idle = 54;
    recv_idle = 35;
    random_items(90);
    drain();

    // Extreme coefficients; w can be negative, and such vertices clip.
    m = '{64'hffff_ffff_ffff_ffff, 64'h0,
          64'h7fff_ffff_7fff_ffff, 64'h8000_0000_8000_0000,
          64'hffff_ffff_ffff_ffff, 64'h0,
          64'h7fff_ffff_7fff_ffff, 64'h8000_0000_8000_0000};
    write_matrix(m);
    send_idle = 0;
    recv_idle = 0;
    random_items(20);
    drain();

    // Back to identity, full rate, with a long result stall up front.
    m = MATRIX_RESET;
    write_matrix(m);
    hold_req = 1;
    random_items(70);
    drain();

    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/vcvc_pkg.sv
rtl/core/vcvc_ifs.sv
rtl/core/vcvc_front.sv
rtl/core/vcvc_div.sv
rtl/core/vcvc_back.sv
rtl/core/vertex_clip_viewport_cull_core.sv
rtl/core/vcvc_checker.sv
sim/vcvc_checker.sv
sim/vertex_clip_viewport_cull_core_tb.sv
